FILE: rtl/homogeneous_point_transform_assert.svh
// ----------------------------------------------------------------------------
// Homogeneous point transform assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define HPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("homogeneous_point_transform: assertion failed");
// Next-cycle implication.
`define HPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("homogeneous_point_transform: assertion failed");
`else
`define HPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define HPT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform package
// Widths, codes, reset values and shared types of the transform pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

   // Action codes of an input item.
   localparam logic [1:0] ACT_VECTOR = 2'd0;
   localparam logic [1:0] ACT_POINT  = 2'd1;
   localparam logic [1:0] ACT_HOMOG  = 2'd2;

   localparam int Q16_W   = 32;
   localparam int PROD_W  = 64;
   localparam int PSUM_W  = 65;
   localparam int SUM_W   = 66;
   localparam int MAG_W   = 66;
   localparam int QUO_W   = 32;
   localparam int REM_W   = MAG_W + QUO_W;
   localparam int FRAC_W  = 16;

   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 64;

   localparam int FRONT_LAT = 3;
   localparam int DIV_LAT   = QUO_W + 3;
   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

   localparam logic signed [Q16_W-1:0] Q16_ONE = 32'sd65536;
   // 1.0 in Q32.32, the divisor of a vector item.
   localparam logic signed [SUM_W-1:0] DEN_ONE = 66'sh1_0000_0000;

   // Matrix register reset values, listed from the highest register index down.
   localparam logic [NUM_REGS-1:0][CSR_DAT_W-1:0] CSR_RESET = {
      64'h0001_0000_0000_0000, 64'h0,
      64'h0000_0000_0001_0000, 64'h0,
      64'h0,                   64'h0001_0000_0000_0000,
      64'h0,                   64'h0000_0000_0001_0000
   };

   typedef logic [3:0][3:0][Q16_W-1:0] coef_mat_type;

   // Row sums handed from the multiply-accumulate front to the dividers.
   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
      logic signed [SUM_W-1:0] den;
   } front_out_type;

endpackage

FILE: rtl/hpt_ifs.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface hpt_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;
   logic signed [31:0] in_w;
   modport source (output valid, action, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, action, in_x, in_y, in_z, in_w, output ready);
endinterface

interface hpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               divide_by_zero;
   modport source (output valid, out_x, out_y, out_z, divide_by_zero, input ready);
   modport sink   (input valid, out_x, out_y, out_z, divide_by_zero, output ready);
endinterface

interface hpt_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hpt_front.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform front end
// Sixteen products, then a two-level adder tree and divisor selection.
// ----------------------------------------------------------------------------
module hpt_front (
   input  logic                  clock,
   input  logic                  en,
   input  hpt_pkg::coef_mat_type coef,
   input  logic [1:0]            action,
   input  logic signed [31:0]    in_x,
   input  logic signed [31:0]    in_y,
   input  logic signed [31:0]    in_z,
   input  logic signed [31:0]    in_w,
   output hpt_pkg::front_out_type sums
);

   logic signed [hpt_pkg::Q16_W-1:0]  vec [4];
   logic signed [hpt_pkg::PROD_W-1:0] prod_ff [4][4];
   logic signed [hpt_pkg::PSUM_W-1:0] psum_ff [4][2];
   logic signed [hpt_pkg::SUM_W-1:0]  sum_in  [4];
   logic                              vec0_ff;
   logic                              vec1_ff;
   hpt_pkg::front_out_type            out_ff;

   // The fourth component depends on the action; code three acts as homogeneous.
   always_comb begin
      vec[0] = in_x;
      vec[1] = in_y;
      vec[2] = in_z;
      case (action)
         hpt_pkg::ACT_VECTOR: vec[3] = '0;
         hpt_pkg::ACT_POINT:  vec[3] = hpt_pkg::Q16_ONE;
         default:             vec[3] = in_w;
      endcase
   end

   // Stage one: all sixteen exact products.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= $signed(coef[r][c]) * vec[c];
            end
         end
         vec0_ff <= (action == hpt_pkg::ACT_VECTOR);
      end
   end

   // Stage two: pairwise sums of each row.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            psum_ff[r][0] <= hpt_pkg::PSUM_W'(prod_ff[r][0]) + hpt_pkg::PSUM_W'(prod_ff[r][1]);
            psum_ff[r][1] <= hpt_pkg::PSUM_W'(prod_ff[r][2]) + hpt_pkg::PSUM_W'(prod_ff[r][3]);
         end
         vec1_ff <= vec0_ff;
      end
   end

   // Stage three: full row sums; a vector divides by exactly one.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = hpt_pkg::SUM_W'(psum_ff[r][0]) + hpt_pkg::SUM_W'(psum_ff[r][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.x   <= sum_in[0];
         out_ff.y   <= sum_in[1];
         out_ff.z   <= sum_in[2];
         out_ff.den <= vec1_ff ? hpt_pkg::DEN_ONE : sum_in[3];
      end
   end

   assign sums = out_ff;

endmodule

FILE: rtl/hpt_div.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform divider lane
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest and saturation to signed Q16.16.
// ----------------------------------------------------------------------------
module hpt_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [hpt_pkg::SUM_W-1:0] num,
   input  logic signed [hpt_pkg::SUM_W-1:0] den,
   output logic signed [hpt_pkg::Q16_W-1:0] quo
);

   localparam int QW = hpt_pkg::QUO_W;
   localparam int MW = hpt_pkg::MAG_W;
   localparam int RW = hpt_pkg::REM_W;

   logic [MW-1:0] nmag_ff;
   logic [MW-1:0] dmag_ff;
   logic          sneg_ff;
   logic [RW-1:0] start_in;

   logic [RW-1:0] rem_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic [MW-1:0] dv_ff  [QW+1];
   logic          neg_ff [QW+1];
   logic          ovf_ff [QW+1];

   logic [QW-1:0] limit;
   logic [QW-1:0] mag;
   logic [QW-1:0] out_ff;

   // Magnitudes and the sign of the quotient.
   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= num[hpt_pkg::SUM_W-1] ? MW'(-num) : MW'(num);
         dmag_ff <= den[hpt_pkg::SUM_W-1] ? MW'(-den) : MW'(den);
         sneg_ff <= num[hpt_pkg::SUM_W-1] ^ den[hpt_pkg::SUM_W-1];
      end
   end

   // Scale the numerator to Q16.16 and add half the divisor for rounding.
   // A quotient of 2^32 or more is flagged here and saturates at the end.
   assign start_in = (RW'(nmag_ff) << hpt_pkg::FRAC_W) + RW'(dmag_ff >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= start_in;
         quo_ff[0] <= '0;
         dv_ff[0]  <= dmag_ff;
         neg_ff[0] <= sneg_ff;
         ovf_ff[0] <= (start_in >= {dmag_ff, {QW{1'b0}}});
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int B = QW - 1 - k;
      logic [RW-1:0] trial;
      assign trial = RW'(dv_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               quo_ff[k+1] <= quo_ff[k] | (QW'(1) << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               quo_ff[k+1] <= quo_ff[k];
            end
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // Saturate the magnitude and apply the sign.
   always_comb begin
      limit = neg_ff[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      mag   = (ovf_ff[QW] || (quo_ff[QW] > limit)) ? limit : quo_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= neg_ff[QW] ? (QW'(0) - mag) : mag;
      end
   end

   assign quo = $signed(out_ff);

endmodule

FILE: rtl/homogeneous_point_transform.sv
// Throughput: one item per cycle while the response is not stalled; three
// multiply and add stages feed three parallel 35-stage divider lanes that
// each retire one quotient bit a stage.
// A stalled response freezes the whole pipeline in place.
// Reset clears the valid pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
// Homogeneous point transform
// Applies a configured 4x4 Q16.16 matrix and the perspective divide.
// ----------------------------------------------------------------------------
`include "homogeneous_point_transform_assert.svh"

module homogeneous_point_transform (
   input  logic   clock,
   input  logic   reset,
   hpt_req_if.sink   req,
   hpt_rsp_if.source rsp,
   hpt_csr_if.sink   csr
);

   localparam int TL = hpt_pkg::TOTAL_LAT;
   localparam int DL = hpt_pkg::DIV_LAT;

   logic [hpt_pkg::CSR_DAT_W-1:0] cfg_ff [hpt_pkg::NUM_REGS];
   hpt_pkg::coef_mat_type         coef;
   hpt_pkg::front_out_type        sums;
   logic                          pipe_en;
   logic [TL-1:0]                 vld_ff;
   logic [DL-1:0]                 dz_ff;
   logic signed [31:0]            qx;
   logic signed [31:0]            qy;
   logic signed [31:0]            qz;

   // Register writes; indexes past the last register are dropped.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= hpt_pkg::CSR_RESET[i];
         end
      end else if (csr.valid && (csr.index < hpt_pkg::CSR_IDX_W'(hpt_pkg::NUM_REGS))) begin
         cfg_ff[csr.index[2:0]] <= csr.data;
      end
   end

   // Unpack the coefficient halves into a matrix.
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         localparam int RI = r * 2 + c / 2;
         localparam int LO = (c % 2) * 32;
         assign coef[r][c] = cfg_ff[RI][LO +: 32];
      end
   end

   // The whole pipeline advances unless a finished result is held.
   assign pipe_en   = !vld_ff[TL-1] || rsp.ready;
   assign req.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[TL-2:0], req.valid};
      end
   end

   // The zero-divisor flag travels beside the divider lanes.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dz_ff <= {dz_ff[DL-2:0], (sums.den == '0)};
      end
   end

   hpt_front u_front (
      .clock  (clock),
      .en     (pipe_en),
      .coef   (coef),
      .action (req.action),
      .in_x   (req.in_x),
      .in_y   (req.in_y),
      .in_z   (req.in_z),
      .in_w   (req.in_w),
      .sums   (sums)
   );

   hpt_div u_div_x (.clock(clock), .en(pipe_en), .num(sums.x), .den(sums.den), .quo(qx));
   hpt_div u_div_y (.clock(clock), .en(pipe_en), .num(sums.y), .den(sums.den), .quo(qy));
   hpt_div u_div_z (.clock(clock), .en(pipe_en), .num(sums.z), .den(sums.den), .quo(qz));

   // A zero divisor forces the components to zero.
   assign rsp.valid          = vld_ff[TL-1];
   assign rsp.divide_by_zero = dz_ff[DL-1];
   assign rsp.out_x          = dz_ff[DL-1] ? '0 : qx;
   assign rsp.out_y          = dz_ff[DL-1] ? '0 : qy;
   assign rsp.out_z          = dz_ff[DL-1] ? '0 : qz;

   // A held result freezes every valid bit of the pipeline.
   `HPT_ASSERT_NXT(a_stall_freezes, clock, reset, !pipe_en, $stable(vld_ff))
   // A zero-divisor result carries zero components.
   `HPT_ASSERT_IMP(a_dz_zero, clock, reset, rsp.valid && rsp.divide_by_zero, (rsp.out_x == 0) && (rsp.out_y == 0) && (rsp.out_z == 0))
   // The pipeline comes out of reset empty.
   `HPT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp.valid && (vld_ff == '0))

endmodule

FILE: test/homogeneous_point_transform_tb.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform testbench
// Streams vectors, points and homogeneous items under several matrix
// settings, predicts each response in exact wide arithmetic and compares
// every transfer field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_tb;

   typedef struct {
      logic [1:0]         action;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] w;
   } point_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               dbz;
   } coord_type;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = hpt_pkg::TOTAL_LAT + 10;

   logic clock;
   logic reset;

   hpt_req_if req();
   hpt_rsp_if rsp();
   hpt_csr_if csr();

   homogeneous_point_transform uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   // Testbench copy of the matrix registers.
   logic [hpt_pkg::CSR_DAT_W-1:0] matrix_regs [hpt_pkg::NUM_REGS];

   point_type pending_points[$];
   coord_type expected_coords[$];
   int        mismatches;
   int        checked;
   int        zero_divides;
   int        cycles;
   int        req_gap;
   int        rsp_gap;
   bit        quiet;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Signed coefficient m[r][c] from the register copy.
   function automatic logic signed [127:0] coef(int r, int c);
      logic [63:0] v;
      v = matrix_regs[r * 2 + c / 2];
      return (c % 2) ? 128'(signed'(v[63:32])) : 128'(signed'(v[31:0]));
   endfunction

   // Rounded, saturated Q16.16 quotient of two Q32.32 sums.
   function automatic logic signed [31:0] q16_quotient(logic signed [127:0] num,
                                                       logic signed [127:0] den);
      logic         neg;
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] q;
      logic [127:0] limit;
      neg   = num[127] ^ den[127];
      n     = num[127] ? -num : num;
      d     = den[127] ? -den : den;
      q     = ((n << 16) + (d >> 1)) / d;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) q = limit;
      return neg ? -q[31:0] : q[31:0];
   endfunction

   // Expected response of one point under the current matrix.
   function automatic coord_type transform_point(point_type p);
      logic signed [127:0] v [4];
      logic signed [127:0] sums [4];
      coord_type           c;
      v[0] = p.x;
      v[1] = p.y;
      v[2] = p.z;
      if (p.action[1]) v[3] = p.w;
      else if (p.action == hpt_pkg::ACT_POINT) v[3] = hpt_pkg::Q16_ONE;
      else v[3] = 0;
      for (int r = 0; r < 4; r++) begin
         sums[r] = 0;
         for (int k = 0; k < 4; k++) sums[r] += coef(r, k) * v[k];
      end
      if (p.action == hpt_pkg::ACT_VECTOR) sums[3] = 128'sh1_0000_0000;
      if (sums[3] == 0) begin
         c = '{0, 0, 0, 1'b1};
      end else begin
         c.x   = q16_quotient(sums[0], sums[3]);
         c.y   = q16_quotient(sums[1], sums[3]);
         c.z   = q16_quotient(sums[2], sums[3]);
         c.dbz = 1'b0;
      end
      return c;
   endfunction

   // Component value: mostly moderate magnitudes, some full range and extremes.
   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      endcase
   endfunction

   function automatic point_type rand_point();
      point_type p;
      p.action = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      p.x = rand_q16();
      p.y = rand_q16();
      p.z = rand_q16();
      case ($urandom_range(0, 4))
         0: p.w = 0;
         1: p.w = hpt_pkg::Q16_ONE;
         default: p.w = rand_q16();
      endcase
      return p;
   endfunction

   // Request driver: predicts each transfer and presents the next point.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req.valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_coords.push_back(transform_point('{req.action, req.in_x,
                                      req.in_y, req.in_z, req.in_w}));
         if (!req.valid || req.ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_points.size() == 0) begin
               req.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
               req_gap   <= $urandom_range(0, 12);
               req.valid <= 1'b0;
            end else begin
               point_type p;
               p = pending_points.pop_front();
               req.valid  <= 1'b1;
               req.action <= p.action;
               req.in_x   <= p.x;
               req.in_y   <= p.y;
               req.in_z   <= p.z;
               req.in_w   <= p.w;
            end
         end
      end
   end

   // Response monitor: checks each transfer and stalls the response at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_coords.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected response transfer");
            end else begin
               coord_type e;
               e = expected_coords.pop_front();
               checked <= checked + 1;
               if (e.dbz) zero_divides <= zero_divides + 1;
               if (rsp.out_x !== e.x || rsp.out_y !== e.y || rsp.out_z !== e.z ||
                   rsp.divide_by_zero !== e.dbz) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                              e.x, e.y, e.z, e.dbz, rsp.out_x, rsp.out_y,
                              rsp.out_z, rsp.divide_by_zero);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_gap   <= $urandom_range(0, 12);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One register write transfer; the copy follows what the block accepts.
   task automatic write_reg(logic [3:0] index, logic [63:0] data);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (index < hpt_pkg::NUM_REGS) matrix_regs[index[2:0]] = data;
   endtask

   // Wait until every expected response has arrived and the pipeline is empty.
   task automatic drain();
      do @(posedge clock);
      while (pending_points.size() != 0 || req.valid || expected_coords.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) pending_points.push_back(rand_point());
      drain();
   endtask

   initial begin
      logic [63:0] d;
      req.valid  = 1'b0;
      req.action = hpt_pkg::ACT_VECTOR;
      req.in_x   = 0;
      req.in_y   = 0;
      req.in_z   = 0;
      req.in_w   = 0;
      rsp.ready  = 1'b0;
      csr.valid  = 1'b0;
      csr.index  = 0;
      csr.data   = 0;
      mismatches = 0;
      checked = 0;
      zero_divides = 0;
      cycles = 0;
      quiet = 1'b0;
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) matrix_regs[i] = hpt_pkg::CSR_RESET[i];
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed points under the reset identity matrix.
      pending_points.push_back('{hpt_pkg::ACT_VECTOR, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0});
      pending_points.push_back('{hpt_pkg::ACT_POINT, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 5});
      pending_points.push_back('{hpt_pkg::ACT_HOMOG, hpt_pkg::Q16_ONE, hpt_pkg::Q16_ONE,
                                 hpt_pkg::Q16_ONE, 0});
      pending_points.push_back('{hpt_pkg::ACT_HOMOG, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1});
      pending_points.push_back('{hpt_pkg::ACT_HOMOG, 32'sh7FFF_FFFF, 3, -3, -1});
      pending_points.push_back('{2'd3, 32'sh0003_0000, 32'sh0001_8000, 7, 32'sh0002_0000});
      pending_points.push_back('{hpt_pkg::ACT_HOMOG, 1, -1, 3, 32'sh0002_0000});
      pending_points.push_back('{hpt_pkg::ACT_HOMOG, -32'sh0001_0000, 2, 1, -32'sh0003_0000});
      drain();

      // Translation, scale and a projective bottom row.
      write_reg(4'd0, {32'sh0000_8000, 32'sh0002_0000});
      write_reg(4'd1, {32'sh0005_0000, 32'sh0000_4000});
      write_reg(4'd2, {32'sh0001_0000, 32'shFFFF_0000});
      write_reg(4'd3, {32'shFFFD_0000, 32'sh0000_0001});
      write_reg(4'd4, {32'sh0000_0003, 32'sh0000_0000});
      write_reg(4'd5, {32'sh0100_0000, 32'sh0000_C000});
      write_reg(4'd6, {32'sh0000_0000, 32'sh0000_0000});
      write_reg(4'd7, {32'sh0001_0000, 32'sh0001_0000});
      write_reg(4'd9, 64'hDEAD_BEEF_0000_0000);
      pending_points.push_back('{hpt_pkg::ACT_POINT, 32'sh0001_0000, 32'sh0002_0000, 0, 0});
      pending_points.push_back('{hpt_pkg::ACT_POINT, 0, 0, -32'sh0001_0000, 0});
      pending_points.push_back('{hpt_pkg::ACT_POINT, 0, 0, 0, 0});
      pending_points.push_back('{hpt_pkg::ACT_VECTOR, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                 32'sh7FFF_FFFF, 0});
      run_random(130);

      // Bottom row zero: every item but a vector divides by zero.
      write_reg(4'd6, 64'h0);
      write_reg(4'd7, 64'h0);
      run_random(90);

      // Extreme coefficients.
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
         write_reg(4'(i), i % 2 ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
      run_random(110);

      // Random full-range and moderate matrices.
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) write_reg(4'(i), {$urandom, $urandom});
      run_random(110);
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
         d[63:32] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         d[31:0]  = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         write_reg(4'(i), d);
      end
      run_random(130);

      // Final stretch back at identity with no idling.
      quiet = 1'b1;
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) write_reg(4'(i), hpt_pkg::CSR_RESET[i]);
      run_random(100);

      $display("Checked %0d responses across seven matrix settings, %0d with a zero divisor.",
               checked, zero_divides);
      $display("Mismatches: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
